FILE: hw/rtl/latency_slo_channel_policy_assert.svh
// Shared assertion macros for the channel policy block.
`ifndef LATENCY_SLO_CHANNEL_POLICY_ASSERT_SVH
`define LATENCY_SLO_CHANNEL_POLICY_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define LSCP_ASSERT_NOW(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, held off during reset.
`define LSCP_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: hw/rtl/lscp_pkg.sv
`timescale 1ns / 1ps
package lscp_pkg;

    localparam int CONFIG_ENTRIES = 16;
    localparam int TEL_ENTRIES    = 64;
    localparam int CFG_IDX_W      = (CONFIG_ENTRIES > 1) ? $clog2(CONFIG_ENTRIES) : 1;
    localparam int TEL_IDX_W      = (TEL_ENTRIES > 1) ? $clog2(TEL_ENTRIES) : 1;
    localparam int FILL_W         = $clog2(TEL_ENTRIES + 1);

    localparam int LAT_W   = 48;
    localparam int CH_W    = 8;
    localparam int CNT_W   = 32;
    localparam int KIND_W  = 4;
    localparam int NODE_W  = 16;
    localparam int KEY_W   = KIND_W + NODE_W;
    localparam int HALF_W  = LAT_W / 2;
    localparam int PROD_W  = HALF_W + CNT_W;
    localparam int DIVD_W  = LAT_W + CNT_W + 1;
    localparam int DCNT_W  = $clog2(DIVD_W);
    localparam int REGI_W  = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Command codes
    localparam logic [1:0] CMD_DECIDE = 2'd0;
    localparam logic [1:0] CMD_CFG_WR = 2'd1;
    localparam logic [1:0] CMD_CFG_RM = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    // Register indexes
    localparam logic [REGI_W-1:0] REG_TARGET    = 3'd0;
    localparam logic [REGI_W-1:0] REG_MIN       = 3'd1;
    localparam logic [REGI_W-1:0] REG_MAX       = 3'd2;
    localparam logic [REGI_W-1:0] REG_STEP      = 3'd3;
    localparam logic [REGI_W-1:0] REG_HOT_TREE  = 3'd4;
    localparam logic [REGI_W-1:0] REG_HOT_LL    = 3'd5;
    localparam logic [REGI_W-1:0] REG_CALM_TREE = 3'd6;

    localparam logic [LAT_W-1:0] RST_TARGET    = 48'd150;
    localparam logic [CH_W-1:0]  RST_MIN       = 8'd1;
    localparam logic [CH_W-1:0]  RST_MAX       = 8'd8;
    localparam logic [CH_W-1:0]  RST_STEP      = 8'd1;
    localparam logic [LAT_W-1:0] RST_HOT_TREE  = 48'd65536;
    localparam logic [LAT_W-1:0] RST_HOT_LL    = 48'd1048576;
    localparam logic [LAT_W-1:0] RST_CALM_TREE = 48'd16384;

    localparam logic [1:0] AGGR_NONE = 2'd0;
    localparam logic [1:0] AGGR_CALM = 2'd1;
    localparam logic [1:0] AGGR_HOT  = 2'd3;
    localparam logic ALGO_TREE    = 1'b0;
    localparam logic ALGO_RING    = 1'b1;
    localparam logic PROTO_LL     = 1'b0;
    localparam logic PROTO_SIMPLE = 1'b1;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [KIND_W-1:0] coll_kind;
        logic [NODE_W-1:0] node_count;
        logic [LAT_W-1:0]  message_bytes;
        logic [LAT_W-1:0]  rolling_p99;
        logic [LAT_W-1:0]  last_latency;
        logic [CH_W-1:0]   current_chan;
        logic [LAT_W-1:0]  entry_target;
        logic [CH_W-1:0]   entry_min;
        logic [CH_W-1:0]   entry_max;
        logic [CH_W-1:0]   entry_step;
    } in_item_t;

    typedef struct packed {
        logic              algo_choice;
        logic              proto_choice;
        logic [CH_W-1:0]   channel_count;
        logic [1:0]        aggression;
        logic              telemetry_stored;
        logic [LAT_W-1:0]  mean_latency;
        logic [LAT_W-1:0]  peak_p99;
        logic [CNT_W-1:0]  sample_count;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SCAN,
        ST_FETCH,
        ST_CALC,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_DIV,
        ST_WB,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic latch;
        logic look;
        logic scan;
        logic fetch;
        logic calc;
        logic mul_lo;
        logic mul_hi;
        logic sum;
        logic div_step;
        logic wb;
        logic fin;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_policy;
        logic scan_done;
        logic div_needed;
        logic div_last;
        logic out_free;
    } ctrl_sts_t;

endpackage

FILE: hw/rtl/lscp_if.sv
`timescale 1ns / 1ps
interface lscp_in_if;
    import lscp_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t item;
    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface lscp_out_if;
    import lscp_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t item;
    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

FILE: hw/rtl/lscp_ctrl.sv
`timescale 1ns / 1ps
module lscp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lscp_pkg::ctrl_sts_t sts,
    output lscp_pkg::ctrl_cmd_t cmd
);
    import lscp_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_LOOK;
            ST_LOOK:   state_next = sts.is_policy ? ST_SCAN : ST_FIN;
            ST_SCAN:   if (sts.scan_done) state_next = ST_FETCH;
            ST_FETCH:  state_next = ST_CALC;
            ST_CALC:   state_next = ST_MUL_LO;
            ST_MUL_LO: state_next = sts.div_needed ? ST_MUL_HI : ST_WB;
            ST_MUL_HI: state_next = ST_SUM;
            ST_SUM:    state_next = ST_DIV;
            ST_DIV:    if (sts.div_last) state_next = ST_WB;
            ST_WB:     state_next = ST_FIN;
            ST_FIN:    if (sts.out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        in_ready     = (state_reg == ST_IDLE);
        cmd.latch    = (state_reg == ST_IDLE) && in_valid;
        cmd.look     = (state_reg == ST_LOOK);
        cmd.scan     = (state_reg == ST_SCAN);
        cmd.fetch    = (state_reg == ST_FETCH);
        cmd.calc     = (state_reg == ST_CALC);
        cmd.mul_lo   = (state_reg == ST_MUL_LO);
        cmd.mul_hi   = (state_reg == ST_MUL_HI);
        cmd.sum      = (state_reg == ST_SUM);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.wb       = (state_reg == ST_WB);
        cmd.fin      = (state_reg == ST_FIN) && sts.out_free;
    end

endmodule

FILE: hw/rtl/lscp_dp.sv
`timescale 1ns / 1ps
module lscp_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [lscp_pkg::REGI_W-1:0] cfg_index,
    input  logic [lscp_pkg::LAT_W-1:0]  cfg_data,
    input  lscp_pkg::in_item_t          in_item,
    input  lscp_pkg::ctrl_cmd_t         cmd,
    output lscp_pkg::ctrl_sts_t         sts,
    output logic                        out_valid,
    input  logic                        out_ready,
    output lscp_pkg::out_item_t         out_item
);
    import lscp_pkg::*;

    function automatic logic [CH_W-1:0] clamp_ch(input logic [CH_W:0] v,
                                                 input logic [CH_W-1:0] lo,
                                                 input logic [CH_W-1:0] hi);
        logic [CH_W-1:0] r;
        if (v < {1'b0, lo})
            r = lo;
        else if (v > {1'b0, hi})
            r = hi;
        else
            r = v[CH_W-1:0];
        return r;
    endfunction

    // Control and status registers
    logic [LAT_W-1:0] r_target_reg, r_hot_tree_reg, r_hot_ll_reg, r_calm_tree_reg;
    logic [CH_W-1:0]  r_min_reg, r_max_reg, r_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_target_reg    <= RST_TARGET;
            r_min_reg       <= RST_MIN;
            r_max_reg       <= RST_MAX;
            r_step_reg      <= RST_STEP;
            r_hot_tree_reg  <= RST_HOT_TREE;
            r_hot_ll_reg    <= RST_HOT_LL;
            r_calm_tree_reg <= RST_CALM_TREE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TARGET:    r_target_reg    <= cfg_data;
                REG_MIN:       r_min_reg       <= cfg_data[CH_W-1:0];
                REG_MAX:       r_max_reg       <= cfg_data[CH_W-1:0];
                REG_STEP:      r_step_reg      <= cfg_data[CH_W-1:0];
                REG_HOT_TREE:  r_hot_tree_reg  <= cfg_data;
                REG_HOT_LL:    r_hot_ll_reg    <= cfg_data;
                REG_CALM_TREE: r_calm_tree_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Latched item
    in_item_t item_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            item_reg <= in_item;
        end
    end

    // Per-kind config table
    logic                  cfg_present_reg [CONFIG_ENTRIES];
    logic [LAT_W-1:0]      cfg_target_reg  [CONFIG_ENTRIES];
    logic [3*CH_W-1:0]     cfg_limits_reg  [CONFIG_ENTRIES];
    logic                  kind_in_range;
    logic [CFG_IDX_W-1:0]  kind_idx;
    logic                  cfg_hit;

    assign kind_in_range = ({1'b0, item_reg.coll_kind} < (KIND_W + 1)'(CONFIG_ENTRIES));
    assign kind_idx      = CFG_IDX_W'(item_reg.coll_kind);
    assign cfg_hit       = kind_in_range && cfg_present_reg[kind_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CONFIG_ENTRIES; i++)
            begin
                cfg_present_reg[i] <= 1'b0;
            end
        end
        else if (cmd.look && kind_in_range)
        begin
            if (item_reg.cmd == CMD_CFG_WR)
                cfg_present_reg[kind_idx] <= 1'b1;
            else if (item_reg.cmd == CMD_CFG_RM)
                cfg_present_reg[kind_idx] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.look && kind_in_range && item_reg.cmd == CMD_CFG_WR)
        begin
            cfg_target_reg[kind_idx] <= item_reg.entry_target;
            cfg_limits_reg[kind_idx] <= {item_reg.entry_step, item_reg.entry_max,
                                         item_reg.entry_min};
        end
    end

    // Selected limits
    logic [LAT_W-1:0] tgt_reg;
    logic [CH_W-1:0]  lo_reg, hi_reg, step_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.look)
        begin
            if (cfg_hit)
            begin
                tgt_reg  <= cfg_target_reg[kind_idx];
                lo_reg   <= cfg_limits_reg[kind_idx][CH_W-1:0];
                hi_reg   <= cfg_limits_reg[kind_idx][2*CH_W-1:CH_W];
                step_reg <= cfg_limits_reg[kind_idx][3*CH_W-1:2*CH_W];
            end
            else
            begin
                tgt_reg  <= r_target_reg;
                lo_reg   <= r_min_reg;
                hi_reg   <= r_max_reg;
                step_reg <= r_step_reg;
            end
        end
    end

    // Telemetry search: entries fill in order and are never freed
    logic [FILL_W-1:0]    fill_reg;
    logic [FILL_W-1:0]    scan_idx_reg;
    logic                 cmp_valid_reg;
    logic [TEL_IDX_W-1:0] cmp_idx_reg;
    logic                 hit_reg;
    logic [TEL_IDX_W-1:0] slot_reg;
    logic [KEY_W-1:0]     key;
    logic [KEY_W-1:0]     key_q_reg;
    logic                 scan_more;
    logic                 tel_full;

    assign key       = {item_reg.node_count, item_reg.coll_kind};
    assign scan_more = (scan_idx_reg < fill_reg);
    assign tel_full  = (fill_reg == FILL_W'(TEL_ENTRIES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else if (cmd.look)
        begin
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else if (cmd.scan)
        begin
            cmp_valid_reg <= scan_more;
            if (scan_more)
                scan_idx_reg <= scan_idx_reg + 1'b1;
            if (cmp_valid_reg && !hit_reg && key_q_reg == key)
                hit_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan)
        begin
            cmp_idx_reg <= scan_idx_reg[TEL_IDX_W-1:0];
            if (cmp_valid_reg && !hit_reg && key_q_reg == key)
                slot_reg <= cmp_idx_reg;
        end
    end

    // Decision results
    logic             algo_reg, proto_reg, stored_reg;
    logic [CH_W-1:0]  ch_reg;
    logic [1:0]       aggr_reg;
    logic [LAT_W-1:0] p99_res_reg, mean_res_reg, mean_op_reg;
    logic [CNT_W-1:0] n_res_reg, n_op_reg;
    logic [LAT_W-1:0] out_next_p99;

    // Running mean operands and divider state
    logic [PROD_W-1:0] plo_reg, phi_reg;
    logic [DIVD_W-1:0] dvd_reg;
    logic [CNT_W:0]    d_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [LAT_W-1:0]  q_reg;
    logic [DCNT_W-1:0] div_cnt_reg;
    logic [CNT_W:0]    rem_sh;
    logic              div_ge;
    logic [CNT_W:0]    rem_sub;

    // Telemetry memories
    logic [KEY_W-1:0] tel_key_mem [TEL_ENTRIES];
    logic [LAT_W-1:0] tel_p99_mem [TEL_ENTRIES];
    logic [LAT_W-1:0] tel_mean_mem [TEL_ENTRIES];
    logic [CNT_W-1:0] tel_n_mem [TEL_ENTRIES];
    logic [LAT_W-1:0] p99_q_reg, mean_q_reg;
    logic [CNT_W-1:0] n_q_reg;
    logic             wr_en;
    logic [TEL_IDX_W-1:0] wr_addr;

    assign wr_en   = cmd.wb && (hit_reg || !tel_full);
    assign wr_addr = hit_reg ? slot_reg : fill_reg[TEL_IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            tel_key_mem[wr_addr] <= key;
        if (cmd.scan)
            key_q_reg <= tel_key_mem[scan_idx_reg[TEL_IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            tel_p99_mem[wr_addr] <= out_next_p99;
        if (cmd.fetch)
            p99_q_reg <= tel_p99_mem[slot_reg];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            tel_mean_mem[wr_addr] <= mean_res_reg;
        if (cmd.fetch)
            mean_q_reg <= tel_mean_mem[slot_reg];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            tel_n_mem[wr_addr] <= n_res_reg;
        if (cmd.fetch)
            n_q_reg <= tel_n_mem[slot_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else if (cmd.wb && !hit_reg && !tel_full)
            fill_reg <= fill_reg + 1'b1;
    end

    // Decision
    logic [LAT_W-1:0] st_p99, observed;
    logic [CH_W-1:0]  ch_start, ch_base, ch_dn;
    logic [CH_W:0]    ch_up;
    logic             hot;
    logic [CNT_W-1:0] n_src;

    assign st_p99   = hit_reg ? p99_q_reg : '0;
    assign n_src    = hit_reg ? n_q_reg : '0;
    assign observed = (item_reg.rolling_p99 != '0) ? item_reg.rolling_p99 : st_p99;
    assign ch_start = (item_reg.current_chan != '0) ? item_reg.current_chan : lo_reg;
    assign ch_base  = clamp_ch({1'b0, ch_start}, lo_reg, hi_reg);
    assign ch_up    = {1'b0, ch_base} + {1'b0, step_reg};
    assign ch_dn    = (ch_base >= step_reg) ? (ch_base - step_reg) : '0;
    assign hot      = (observed > tgt_reg);

    assign out_next_p99 = p99_res_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.look && item_reg.cmd != CMD_DECIDE)
        begin
            algo_reg     <= ALGO_TREE;
            proto_reg    <= PROTO_LL;
            ch_reg       <= '0;
            aggr_reg     <= AGGR_NONE;
            p99_res_reg  <= '0;
            mean_res_reg <= '0;
            n_res_reg    <= '0;
        end
        else if (cmd.calc)
        begin
            if (hot)
            begin
                ch_reg    <= clamp_ch(ch_up, lo_reg, hi_reg);
                algo_reg  <= (item_reg.message_bytes < r_hot_tree_reg) ? ALGO_TREE : ALGO_RING;
                proto_reg <= (item_reg.message_bytes < r_hot_ll_reg) ? PROTO_LL : PROTO_SIMPLE;
                aggr_reg  <= AGGR_HOT;
            end
            else
            begin
                ch_reg    <= clamp_ch({1'b0, ch_dn}, lo_reg, hi_reg);
                algo_reg  <= (item_reg.message_bytes < r_calm_tree_reg) ? ALGO_TREE : ALGO_RING;
                proto_reg <= PROTO_SIMPLE;
                aggr_reg  <= AGGR_CALM;
            end
            p99_res_reg  <= (observed > item_reg.last_latency) ? observed
                                                               : item_reg.last_latency;
            mean_res_reg <= item_reg.last_latency;
            n_res_reg    <= (n_src == CNT_MAX) ? CNT_MAX : n_src + 1'b1;
            mean_op_reg  <= hit_reg ? mean_q_reg : '0;
            n_op_reg     <= n_src;
        end
        else if (cmd.div_step && sts.div_last)
        begin
            mean_res_reg <= {q_reg[LAT_W-2:0], div_ge};
        end
    end

    // Running mean: (mean * n + last) / (n + 1), product in two halves
    assign rem_sh  = {rem_reg, dvd_reg[DIVD_W-1]};
    assign div_ge  = (rem_sh >= d_reg);
    assign rem_sub = rem_sh - d_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_lo)
            plo_reg <= mean_op_reg[HALF_W-1:0] * n_op_reg;
        if (cmd.mul_hi)
            phi_reg <= mean_op_reg[LAT_W-1:HALF_W] * n_op_reg;
        if (cmd.sum)
        begin
            dvd_reg     <= DIVD_W'(plo_reg) + (DIVD_W'(phi_reg) << HALF_W)
                           + DIVD_W'(item_reg.last_latency);
            d_reg       <= {1'b0, n_op_reg} + 1'b1;
            rem_reg     <= '0;
            q_reg       <= '0;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg     <= {dvd_reg[DIVD_W-2:0], 1'b0};
            rem_reg     <= div_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            q_reg       <= {q_reg[LAT_W-2:0], div_ge};
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stored_reg <= 1'b0;
        else if (cmd.look)
            stored_reg <= 1'b0;
        else if (cmd.wb)
            stored_reg <= hit_reg || !tel_full;
    end

    // Output register
    logic      out_valid_reg;
    out_item_t out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.fin)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            out_item_reg.algo_choice      <= algo_reg;
            out_item_reg.proto_choice     <= proto_reg;
            out_item_reg.channel_count    <= ch_reg;
            out_item_reg.aggression       <= aggr_reg;
            out_item_reg.telemetry_stored <= stored_reg;
            out_item_reg.mean_latency     <= mean_res_reg;
            out_item_reg.peak_p99         <= p99_res_reg;
            out_item_reg.sample_count     <= n_res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign sts.is_policy  = (item_reg.cmd == CMD_DECIDE);
    assign sts.scan_done  = hit_reg || (!scan_more && !cmp_valid_reg);
    assign sts.div_needed = (n_op_reg != '0);
    assign sts.div_last   = (div_cnt_reg == DCNT_W'(DIVD_W - 1));
    assign sts.out_free   = !out_valid_reg || out_ready;

endmodule

FILE: hw/rtl/latency_slo_channel_policy.sv
`timescale 1ns / 1ps
// Latency-target channel policy: one item per collective call. A decision item
// looks up the per-kind limits (falling back to the default registers), scans
// the telemetry table for its (kind, node count) key one entry a cycle, moves
// the channel count up or down by the step within the limits, picks algorithm
// and protocol from the size thresholds, and updates the telemetry entry with
// the running mean, peak p99 and saturating sample count. The scan reads up to
// F entries, F being the number of filled telemetry entries (at most 64); a
// known key with samples adds the mean product in two halves and the
// restoring divider, one quotient bit per cycle. Config-entry items skip the
// scan and the decision. One item is in flight at a time; the next is taken
// while the previous result still waits in the output register. Telemetry
// entries are never freed: once all 64 are in use new keys are reported but
// not stored.
module latency_slo_channel_policy (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [lscp_pkg::REGI_W-1:0] cfg_index,
    input  logic [lscp_pkg::LAT_W-1:0]  cfg_data,
    lscp_in_if.sink                     in_ch,
    lscp_out_if.source                  out_ch
);
    import lscp_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // Sequencer: owns the input handshake and steps the datapath
    lscp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: registers, tables, search, divider and output register
    lscp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_ch.item),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_item  (out_ch.item)
    );

endmodule

FILE: hw/rtl/lscp_checker.sv
`timescale 1ns / 1ps
`include "latency_slo_channel_policy_assert.svh"
module lscp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input lscp_pkg::out_item_t out_item
);
    import lscp_pkg::*;

    // A waiting result holds
    `LSCP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_item))
    // One item at a time: ready drops after an accept
    `LSCP_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)
    // Config results are all zero
    `LSCP_ASSERT_NOW(a_cfg_zero, clk, rst_n, out_valid && out_item.aggression == AGGR_NONE, out_item.channel_count == '0 && out_item.sample_count == '0 && !out_item.telemetry_stored)
    // Within target always uses the simple protocol
    `LSCP_ASSERT_NOW(a_calm_simple, clk, rst_n, out_valid && out_item.aggression == AGGR_CALM, out_item.proto_choice == PROTO_SIMPLE)
    // A decision always counts at least one sample
    `LSCP_ASSERT_NOW(a_decide_count, clk, rst_n, out_valid && out_item.aggression != AGGR_NONE, out_item.sample_count != '0)

endmodule

bind latency_slo_channel_policy lscp_checker u_lscp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_ch.item)
);

FILE: bench/latency_slo_channel_policy_tb.sv
`timescale 1ns / 1ps
module latency_slo_channel_policy_tb;
    import lscp_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [REGI_W-1:0]    cfg_index;
    logic [LAT_W-1:0]     cfg_data;

    lscp_in_if  in_ch ();
    lscp_out_if out_ch ();

    latency_slo_channel_policy i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    // Mirror of the block's registers and tables
    logic [LAT_W-1:0]  m_target, m_hot_tree, m_hot_ll, m_calm_tree;
    logic [CH_W-1:0]   m_min, m_max, m_step;
    logic              m_cfg_present [CONFIG_ENTRIES];
    logic [LAT_W-1:0]  m_cfg_target  [CONFIG_ENTRIES];
    logic [CH_W-1:0]   m_cfg_min     [CONFIG_ENTRIES];
    logic [CH_W-1:0]   m_cfg_max     [CONFIG_ENTRIES];
    logic [CH_W-1:0]   m_cfg_step    [CONFIG_ENTRIES];
    logic              m_tel_present [TEL_ENTRIES];
    logic [KEY_W-1:0]  m_tel_key     [TEL_ENTRIES];
    logic [LAT_W-1:0]  m_tel_p99     [TEL_ENTRIES];
    logic [LAT_W-1:0]  m_tel_mean    [TEL_ENTRIES];
    logic [CNT_W-1:0]  m_tel_samples [TEL_ENTRIES];

    out_item_t decisions_due [$];
    int        mismatches;
    int        idle_cycles;
    bit        sink_hold;
    int        sink_hold_len;

    // Node counts kept to a small pool so keys recur and the mean path runs
    logic [NODE_W-1:0] node_pool [8];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [CH_W-1:0] clamp_chan(input logic [8:0] v,
                                                   input logic [CH_W-1:0] lo,
                                                   input logic [CH_W-1:0] hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v[CH_W-1:0];
    endfunction

    // Work out the decision for one item and advance the mirrored state
    function automatic out_item_t predict_decision(input in_item_t it);
        out_item_t         res;
        logic [LAT_W-1:0]  tgt, observed, stored_p99, mean;
        logic [CH_W-1:0]   lo, hi, stp, ch;
        logic [CNT_W-1:0]  n;
        logic [KEY_W-1:0]  key;
        logic [127:0]      total;
        int                slot, free_slot;
        res = '0;
        if (it.cmd == CMD_CFG_WR || it.cmd == CMD_CFG_RM)
        begin
            if (it.cmd == CMD_CFG_WR)
            begin
                m_cfg_present[it.coll_kind] = 1'b1;
                m_cfg_target[it.coll_kind]  = it.entry_target;
                m_cfg_min[it.coll_kind]     = it.entry_min;
                m_cfg_max[it.coll_kind]     = it.entry_max;
                m_cfg_step[it.coll_kind]    = it.entry_step;
            end
            else
                m_cfg_present[it.coll_kind] = 1'b0;
            return res;
        end
        if (it.cmd != CMD_DECIDE)
            return res;
        if (m_cfg_present[it.coll_kind])
        begin
            tgt = m_cfg_target[it.coll_kind];
            lo  = m_cfg_min[it.coll_kind];
            hi  = m_cfg_max[it.coll_kind];
            stp = m_cfg_step[it.coll_kind];
        end
        else
        begin
            tgt = m_target; lo = m_min; hi = m_max; stp = m_step;
        end
        key = {it.node_count, it.coll_kind};
        slot = -1;
        free_slot = -1;
        for (int i = 0; i < TEL_ENTRIES; i++)
        begin
            if (m_tel_present[i])
            begin
                if (slot < 0 && m_tel_key[i] == key) slot = i;
            end
            else if (free_slot < 0)
                free_slot = i;
        end
        stored_p99 = '0; mean = '0; n = '0;
        if (slot >= 0)
        begin
            stored_p99 = m_tel_p99[slot];
            mean = m_tel_mean[slot];
            n = m_tel_samples[slot];
        end
        observed = (it.rolling_p99 != 0) ? it.rolling_p99 : stored_p99;
        ch = clamp_chan({1'b0, (it.current_chan != 0) ? it.current_chan : lo}, lo, hi);
        if (observed > tgt)
        begin
            ch = clamp_chan({1'b0, ch} + {1'b0, stp}, lo, hi);
            res.algo_choice  = (it.message_bytes < m_hot_tree) ? ALGO_TREE : ALGO_RING;
            res.proto_choice = (it.message_bytes < m_hot_ll) ? PROTO_LL : PROTO_SIMPLE;
            res.aggression   = AGGR_HOT;
        end
        else
        begin
            ch = clamp_chan((ch >= stp) ? {1'b0, ch - stp} : 9'd0, lo, hi);
            res.algo_choice  = (it.message_bytes < m_calm_tree) ? ALGO_TREE : ALGO_RING;
            res.proto_choice = PROTO_SIMPLE;
            res.aggression   = AGGR_CALM;
        end
        res.channel_count = ch;
        if (n == 0)
            res.mean_latency = it.last_latency;
        else
        begin
            total = 128'(mean) * 128'(n) + 128'(it.last_latency);
            res.mean_latency = LAT_W'(total / (128'(n) + 128'd1));
        end
        res.peak_p99 = (observed > it.last_latency) ? observed : it.last_latency;
        res.sample_count = (n == CNT_MAX) ? CNT_MAX : n + 1'b1;
        if (slot < 0 && free_slot >= 0)
        begin
            slot = free_slot;
            m_tel_present[slot] = 1'b1;
            m_tel_key[slot] = key;
        end
        if (slot >= 0)
        begin
            m_tel_p99[slot]     = res.peak_p99;
            m_tel_mean[slot]    = res.mean_latency;
            m_tel_samples[slot] = res.sample_count;
            res.telemetry_stored = 1'b1;
        end
        return res;
    endfunction

    // Send one item: wait the drawn gap, offer it, hold until taken
    task automatic send_item(input in_item_t it, input bit no_gap = 1'b0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.item  <= it;
        in_ch.valid <= 1'b1;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        decisions_due.push_back(predict_decision(it));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (decisions_due.size() != 0) @(negedge clk);
        // a config item has no latency worth waiting on, but let the engine settle
        repeat (200) @(negedge clk);
    endtask

    // Write one register; only called with the block idle
    task automatic write_reg(input logic [REGI_W-1:0] idx, input logic [LAT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_TARGET:    m_target    = val;
            REG_MIN:       m_min       = val[CH_W-1:0];
            REG_MAX:       m_max       = val[CH_W-1:0];
            REG_STEP:      m_step      = val[CH_W-1:0];
            REG_HOT_TREE:  m_hot_tree  = val;
            REG_HOT_LL:    m_hot_ll    = val;
            REG_CALM_TREE: m_calm_tree = val;
            default: ;
        endcase
        @(negedge clk);
    endtask

    function automatic logic [LAT_W-1:0] rand_lat();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return LAT_W'($urandom_range(0, 400));
            3: return LAT_W'($urandom_range(0, 1 << 21));
            default: return LAT_W'({$urandom, $urandom});
        endcase
    endfunction

    function automatic in_item_t rand_decision();
        in_item_t it;
        it = '0;
        it.cmd           = CMD_DECIDE;
        it.coll_kind     = KIND_W'($urandom);
        it.node_count    = node_pool[$urandom_range(0, 7)];
        it.message_bytes = rand_lat();
        it.rolling_p99   = ($urandom_range(0, 2) == 0) ? '0 : rand_lat();
        it.last_latency  = rand_lat();
        it.current_chan  = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
        it.entry_target  = LAT_W'({$urandom, $urandom});
        it.entry_min     = CH_W'($urandom);
        it.entry_max     = CH_W'($urandom);
        it.entry_step    = CH_W'($urandom);
        return it;
    endfunction

    function automatic in_item_t rand_cfg_item();
        in_item_t it;
        it = rand_decision();
        it.cmd = ($urandom_range(0, 3) == 0) ? CMD_CFG_RM : CMD_CFG_WR;
        it.entry_target = rand_lat();
        it.entry_min = CH_W'($urandom_range(0, 6));
        it.entry_max = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(2, 16));
        it.entry_step = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
        return it;
    endfunction

    task automatic send_mix(input int count);
        in_item_t it;
        for (int k = 0; k < count; k++)
        begin
            case ($urandom_range(0, 19))
                0, 1: it = rand_cfg_item();
                2: begin it = rand_decision(); it.cmd = CMD_NONE; end
                default: it = rand_decision();
            endcase
            send_item(it);
        end
    endtask

    // Extremes of fields, every command, unused command, clamping and floor cases
    task automatic test_directed();
        in_item_t it;
        it = '0;
        it.cmd = CMD_DECIDE; it.coll_kind = 4'd3; it.node_count = 16'd1;
        send_item(it);                                   // unknown channels, calm
        it.rolling_p99 = '1; it.last_latency = '1; it.message_bytes = '1;
        it.current_chan = 8'hff;
        send_item(it);                                   // hot, above max
        it.rolling_p99 = '0; it.last_latency = 48'd5;
        send_item(it);                                   // stored p99 reused, mean path
        it = '1; it.cmd = CMD_CFG_WR; it.coll_kind = 4'd15;
        send_item(it);                                   // all-ones entry
        it.cmd = CMD_DECIDE; it.node_count = 16'hffff;
        send_item(it);
        it = '0; it.cmd = CMD_CFG_WR; it.coll_kind = 4'd7;
        it.entry_target = 48'd10; it.entry_min = 8'd4; it.entry_max = 8'd2;
        it.entry_step = 8'd200;
        send_item(it);                                   // min above max
        it.cmd = CMD_DECIDE; it.current_chan = 8'd3; it.last_latency = 48'd9;
        send_item(it);                                   // step past zero
        it.rolling_p99 = 48'd11; it.current_chan = 8'd255;
        send_item(it);
        it.cmd = CMD_CFG_RM;
        send_item(it);
        it.cmd = CMD_DECIDE;
        send_item(it);                                   // back on defaults
        it = '1; it.cmd = CMD_NONE;
        send_item(it);                                   // unused command
        it = '0; it.message_bytes = 48'd65535; it.rolling_p99 = 48'd151;
        send_item(it);
        it.message_bytes = 48'd65536;
        send_item(it);
        it.message_bytes = 48'd1048576; it.rolling_p99 = 48'd150;
        send_item(it);
        it.message_bytes = 48'd16383;
        send_item(it);
        wait_drained();
    endtask

    // Fill the telemetry table, then show that new keys are no longer stored
    task automatic test_table_full();
        in_item_t it;
        for (int k = 0; k < TEL_ENTRIES + 6; k++)
        begin
            it = rand_decision();
            it.node_count = 16'h8000 + 16'(k);
            send_item(it);
        end
        wait_drained();
    endtask

    // Receiver holds off long while the sender keeps offering items
    task automatic test_backpressure();
        sink_hold_len = 1500;
        sink_hold = 1'b1;
        for (int k = 0; k < 12; k++)
            send_item(rand_decision(), 1'b1);
        wait_drained();
    endtask

    task automatic test_register_sweep();
        logic [LAT_W-1:0] vals [4];
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: begin vals = '{'0, '0, '0, '0}; end
                1: begin vals = '{'1, '1, '1, '1}; end
                default: vals = '{rand_lat(), rand_lat(), rand_lat(), rand_lat()};
            endcase
            write_reg(REG_TARGET, vals[0]);
            write_reg(REG_MIN, (phase == 1) ? '1 : LAT_W'($urandom_range(0, 4)));
            write_reg(REG_MAX, (phase == 0) ? '0 : LAT_W'($urandom_range(2, 255)));
            write_reg(REG_STEP, (phase < 2) ? vals[0] : LAT_W'($urandom_range(0, 5)));
            write_reg(REG_HOT_TREE, vals[1]);
            write_reg(REG_HOT_LL, vals[2]);
            write_reg(REG_CALM_TREE, vals[3]);
            send_mix(60);
            wait_drained();
        end
        write_reg(REG_TARGET, RST_TARGET);
        write_reg(REG_MIN, RST_MIN);
        write_reg(REG_MAX, RST_MAX);
        write_reg(REG_STEP, RST_STEP);
        write_reg(REG_HOT_TREE, RST_HOT_TREE);
        write_reg(REG_HOT_LL, RST_HOT_LL);
        write_reg(REG_CALM_TREE, RST_CALM_TREE);
    endtask

    task automatic test_random();
        for (int blk = 0; blk < 10; blk++)
        begin
            send_mix(110);
            // pause the sender until every decision is back
            if (blk == 4)
            begin
                in_ch.valid <= 1'b0;
                while (decisions_due.size() != 0) @(negedge clk);
            end
        end
        wait_drained();
    endtask

    // Stimulus
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        in_ch.valid = 1'b0; in_ch.item = '0;
        mismatches = 0;
        sink_hold = 1'b0;
        sink_hold_len = 0;
        m_target = RST_TARGET; m_min = RST_MIN; m_max = RST_MAX; m_step = RST_STEP;
        m_hot_tree = RST_HOT_TREE; m_hot_ll = RST_HOT_LL; m_calm_tree = RST_CALM_TREE;
        for (int i = 0; i < CONFIG_ENTRIES; i++) m_cfg_present[i] = 1'b0;
        for (int i = 0; i < TEL_ENTRIES; i++) m_tel_present[i] = 1'b0;
        node_pool = '{16'd0, 16'd1, 16'd2, 16'd8, 16'd64, 16'd255, 16'h7fff, 16'hffff};
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_backpressure();
        test_register_sweep();
        test_random();
        test_table_full();
        send_mix(40);
        wait_drained();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Receiver: random stalls drawn per item, long hold-off when asked
    initial
    begin
        int gap;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold)
            begin
                out_ch.ready <= 1'b0;
                repeat (sink_hold_len) @(negedge clk);
                sink_hold = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (gap != 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.item;
            if (decisions_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = decisions_due.pop_front();
                if (got.algo_choice !== want.algo_choice
                    || got.proto_choice !== want.proto_choice
                    || got.channel_count !== want.channel_count
                    || got.aggression !== want.aggression
                    || got.telemetry_stored !== want.telemetry_stored
                    || got.mean_latency !== want.mean_latency
                    || got.peak_p99 !== want.peak_p99
                    || got.sample_count !== want.sample_count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    // Watchdog: count cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial idle_cycles = 0;

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/lscp_pkg.sv
hw/rtl/lscp_if.sv
hw/rtl/lscp_ctrl.sv
hw/rtl/lscp_dp.sv
hw/rtl/latency_slo_channel_policy.sv
hw/rtl/lscp_checker.sv
bench/latency_slo_channel_policy_tb.sv
